@@ rtl/core/ggfi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggfi_pkg: shared types and constants of the gaze gap-fill interpolator
// Beat layouts of the sample channels, configuration codes and reset values.
// ----------------------------------------------------------------------------
package ggfi_pkg;

    localparam int MAX_INSERTS_DEF = 63;
    localparam int NUM_COORDS      = 8;
    localparam int COORD_W         = 24;
    localparam int TIME_W          = 32;
    localparam int TAG_W           = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 1;
    localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_GAP = 1'b0,
        CFG_PERIOD  = 1'b1
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Input beat.
    typedef struct packed {
        logic [TIME_W-1:0] timestamp;
        coord_t            screen_x;
        coord_t            screen_y;
        coord_t            origin_x;
        coord_t            origin_y;
        coord_t            origin_z;
        coord_t            target_x;
        coord_t            target_y;
        coord_t            target_z;
        logic [TAG_W-1:0]  trial_number;
        logic [TAG_W-1:0]  label_tag;
    } ggfi_in_t;

    // Output beat.
    typedef struct packed {
        logic [TIME_W-1:0] out_timestamp;
        coord_t            out_screen_x;
        coord_t            out_screen_y;
        coord_t            out_origin_x;
        coord_t            out_origin_y;
        coord_t            out_origin_z;
        coord_t            out_target_x;
        coord_t            out_target_y;
        coord_t            out_target_z;
        logic [TAG_W-1:0]  out_trial_number;
        logic [TAG_W-1:0]  out_label_tag;
        logic              is_last;
    } ggfi_out_t;

endpackage : ggfi_pkg
`default_nettype wire

@@ rtl/core/ggfi_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggfi_if: valid/ready channels of the gaze gap-fill interpolator
// One interface for incoming samples and one for emitted samples.
// ----------------------------------------------------------------------------
interface ggfi_in_if import ggfi_pkg::*; ();
    logic     valid;
    logic     ready;
    ggfi_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : ggfi_in_if

interface ggfi_out_if import ggfi_pkg::*; ();
    logic      valid;
    logic      ready;
    ggfi_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : ggfi_out_if
`default_nettype wire

@@ rtl/core/gaze_gap_fill_interpolator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaze_gap_fill_interpolator_core: gaze sample gap filler
// Keeps the previous sample and, when a gap is found, emits linearly
// interpolated samples before the new one.
//
//   channel     dir  handshake        beat
//   sample_in   in   valid / ready    ggfi_in_t
//   sample_out  out  valid / ready    ggfi_out_t
//   cfg         in   cfg_we           cfg_index, cfg_wdata
//
// A passed-through sample is packed in S_PACK and offered from S_LAST until taken.
// A gap first runs the insert-count division, then each inserted sample runs
// one multiply and one division per coordinate, all on the single shared divider
// (DIV_W is 34 at the default MAX_INSERTS), and waits on output stalls.
// Reset clears the control state and sets the period register to 1000.
// sample_in is ready only while no sample is in work.
// ----------------------------------------------------------------------------
module gaze_gap_fill_interpolator_core import ggfi_pkg::*; #(
    parameter int MAX_INSERTS = MAX_INSERTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    ggfi_in_if.sink                    sample_in,
    ggfi_out_if.source                 sample_out
);

    localparam int K_W    = $clog2(MAX_INSERTS + 2);
    localparam int PROD_W = 26 + K_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DIV_W  = (26 + K_W > 34) ? 26 + K_W : 34;
    localparam int CRD_W  = $clog2(NUM_COORDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_MUL,
        S_DIV,
        S_PACK,
        S_EMIT,
        S_LAST
    } state_t;

    state_t                   state_reg;
    logic [TIME_W-1:0]        max_gap_reg;
    logic [TIME_W-1:0]        period_reg;
    logic                     have_prev_reg;
    logic [TIME_W-1:0]        prev_time_reg;
    coord_t                   prev_reg [NUM_COORDS];
    coord_t                   now_reg [NUM_COORDS];
    coord_t                   interp_reg [NUM_COORDS];
    ggfi_in_t                 new_reg;
    logic [K_W-1:0]           n_reg;
    logic [K_W-1:0]           k_reg;
    logic [CRD_W-1:0]         j_reg;
    logic [TIME_W-1:0]        ts_acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DIV_W-1:0]         gap_num_reg;
    logic                     start_reg;
    logic                     out_valid_reg;
    ggfi_out_t                out_reg;

    logic                     in_accept;
    logic                     out_accept;
    logic [TIME_W:0]          gap;
    logic                     fill;
    logic [TIME_W+1:0]        gap_num;
    logic signed [25:0]       diff;
    logic signed [NUM_W-1:0]  coord_num;
    logic                     coord_neg;
    logic [NUM_W-1:0]         coord_mag;
    logic [K_W:0]             den2;
    logic [DIV_W-1:0]         div_numer;
    logic [DIV_W-1:0]         div_denom;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic                     div_rnz;
    logic [DIV_W-1:0]         fq;
    ggfi_out_t                last_beat;
    coord_t                   in_coords [NUM_COORDS];

    assign in_accept  = sample_in.valid && sample_in.ready;
    assign out_accept = sample_out.valid && sample_out.ready;
    assign sample_in.ready  = (state_reg == S_IDLE);
    assign sample_out.valid = out_valid_reg;
    assign sample_out.data  = out_reg;

    // Coordinates of the incoming beat in kept-sample order.
    assign in_coords[0] = sample_in.data.screen_x;
    assign in_coords[1] = sample_in.data.screen_y;
    assign in_coords[2] = sample_in.data.origin_x;
    assign in_coords[3] = sample_in.data.origin_y;
    assign in_coords[4] = sample_in.data.origin_z;
    assign in_coords[5] = sample_in.data.target_x;
    assign in_coords[6] = sample_in.data.target_y;
    assign in_coords[7] = sample_in.data.target_z;

    // Gap test and rounded insert-count numerator for the incoming beat.
    always_comb
    begin
        gap     = {1'b0, sample_in.data.timestamp} - {1'b0, prev_time_reg};
        gap_num = {1'b0, gap[TIME_W-1:0], 1'b0} + {2'b00, period_reg};
        fill    = have_prev_reg && (max_gap_reg != '0) && (period_reg != '0)
                  && !gap[TIME_W] && (gap[TIME_W-1:0] > period_reg)
                  && (gap[TIME_W-1:0] <= max_gap_reg);
    end

    // Interpolation numerator 2 * diff * k + (n + 1), split into sign and size.
    always_comb
    begin
        diff      = 26'(now_reg[j_reg]) - 26'(prev_reg[j_reg]);
        den2      = {n_reg + 1'b1, 1'b0};
        coord_num = NUM_W'($signed({prod_reg, 1'b0})) + NUM_W'({1'b0, n_reg + 1'b1});
        coord_neg = coord_num[NUM_W-1];
        coord_mag = coord_neg ? NUM_W'(-coord_num) : NUM_W'(coord_num);
    end

    // Floor of the signed quotient.
    assign fq = coord_neg ? (DIV_W'(0) - (div_quo + DIV_W'(div_rnz))) : div_quo;

    // Divider operands: insert count first, then one coordinate at a time.
    always_comb
    begin
        if (state_reg == S_GAP)
        begin
            div_numer = gap_num_reg;
            div_denom = DIV_W'({1'b0, period_reg, 1'b0});
        end
        else
        begin
            div_numer = DIV_W'(coord_mag);
            div_denom = DIV_W'(den2);
        end
    end

    ggfi_divider #(
        .DIV_W (DIV_W)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start_reg),
        .numer       (div_numer),
        .denom       (div_denom),
        .done        (div_done),
        .quotient    (div_quo),
        .rem_nonzero (div_rnz)
    );

    // The real sample as an output beat.
    always_comb
    begin
        last_beat.out_timestamp    = new_reg.timestamp;
        last_beat.out_screen_x     = new_reg.screen_x;
        last_beat.out_screen_y     = new_reg.screen_y;
        last_beat.out_origin_x     = new_reg.origin_x;
        last_beat.out_origin_y     = new_reg.origin_y;
        last_beat.out_origin_z     = new_reg.origin_z;
        last_beat.out_target_x     = new_reg.target_x;
        last_beat.out_target_y     = new_reg.target_y;
        last_beat.out_target_z     = new_reg.target_z;
        last_beat.out_trial_number = new_reg.trial_number;
        last_beat.out_label_tag    = new_reg.label_tag;
        last_beat.is_last          = 1'b1;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg <= '0;
            period_reg  <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_GAP: max_gap_reg <= cfg_wdata;
                CFG_PERIOD:  period_reg  <= cfg_wdata;
                default:     max_gap_reg <= max_gap_reg;
            endcase
        end
    end

    // Sequencer with its datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        new_reg     <= sample_in.data;
                        now_reg     <= in_coords;
                        gap_num_reg <= DIV_W'(gap_num);
                        if (fill)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_GAP;
                        end
                        else
                        begin
                            state_reg <= S_PACK;
                            n_reg     <= '0;
                        end
                    end
                end
                S_GAP:
                begin
                    if (div_done)
                    begin
                        if (div_quo <= DIV_W'(1))
                        begin
                            n_reg     <= '0;
                            state_reg <= S_PACK;
                        end
                        else
                        begin
                            if (div_quo > DIV_W'(MAX_INSERTS + 1))
                                n_reg <= K_W'(MAX_INSERTS);
                            else
                                n_reg <= K_W'(div_quo - DIV_W'(1));
                            k_reg      <= K_W'(1);
                            j_reg      <= '0;
                            ts_acc_reg <= prev_time_reg + period_reg;
                            state_reg  <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(diff) * PROD_W'($signed({1'b0, k_reg}));
                    start_reg <= 1'b1;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        interp_reg[j_reg] <= prev_reg[j_reg] + coord_t'(fq[COORD_W-1:0]);
                        j_reg <= j_reg + 1'b1;
                        if (j_reg == CRD_W'(NUM_COORDS - 1))
                            state_reg <= S_PACK;
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_PACK:
                begin
                    // An inserted beat while k runs up to n, else the real one.
                    out_valid_reg <= 1'b1;
                    if (n_reg == '0)
                    begin
                        out_reg   <= last_beat;
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        out_reg.out_timestamp    <= ts_acc_reg;
                        out_reg.out_screen_x     <= interp_reg[0];
                        out_reg.out_screen_y     <= interp_reg[1];
                        out_reg.out_origin_x     <= interp_reg[2];
                        out_reg.out_origin_y     <= interp_reg[3];
                        out_reg.out_origin_z     <= interp_reg[4];
                        out_reg.out_target_x     <= interp_reg[5];
                        out_reg.out_target_y     <= interp_reg[6];
                        out_reg.out_target_z     <= interp_reg[7];
                        out_reg.out_trial_number <= new_reg.trial_number;
                        out_reg.out_label_tag    <= new_reg.label_tag;
                        out_reg.is_last          <= 1'b0;
                        state_reg                <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_accept)
                    begin
                        if (k_reg == n_reg)
                        begin
                            out_reg   <= last_beat;
                            state_reg <= S_LAST;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            k_reg         <= k_reg + 1'b1;
                            j_reg         <= '0;
                            ts_acc_reg    <= ts_acc_reg + period_reg;
                            state_reg     <= S_MUL;
                        end
                    end
                end
                S_LAST:
                begin
                    if (out_accept)
                    begin
                        out_valid_reg <= 1'b0;
                        have_prev_reg <= 1'b1;
                        prev_time_reg <= new_reg.timestamp;
                        prev_reg      <= now_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule : gaze_gap_fill_interpolator_core
`default_nettype wire

@@ rtl/core/ggfi_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggfi_divider: shared restoring divider
// Unsigned division, one quotient bit per cycle while an operation is busy.
// ----------------------------------------------------------------------------
module ggfi_divider import ggfi_pkg::*; #(
    parameter int DIV_W = 36
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] numer,
    input  wire logic [DIV_W-1:0] denom,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient,
    output logic                  rem_nonzero
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W:0]   rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             bit_next;
    logic [DIV_W:0]   shifted;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = shifted - {1'b0, den_reg};
            bit_next = 1'b1;
        end
        else
        begin
            rem_next = shifted;
            bit_next = 1'b0;
        end
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= numer;
                den_reg  <= denom;
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_W-2:0], bit_next};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);

endmodule : ggfi_divider
`default_nettype wire

@@ rtl/core/ggfi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggfi_checker: port-level checks of the gaze gap-fill interpolator
// Watches the two sample channels and reports breaches by $error.
// ----------------------------------------------------------------------------
module ggfi_checker import ggfi_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_is_last
);

    // A stalled output beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat withdrawn while stalled");

    // The block never takes a sample while a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");

    // A taken sample keeps the input closed until its results are out.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after a taken beat");

    // Delivering the real sample frees the input in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_is_last |=> in_ready)
        else $error("input not ready after the final beat");

endmodule : ggfi_checker

bind gaze_gap_fill_interpolator_core ggfi_checker u_ggfi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_in.valid),
    .in_ready    (sample_in.ready),
    .out_valid   (sample_out.valid),
    .out_ready   (sample_out.ready),
    .out_is_last (sample_out.data.is_last)
);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: gaze gap-fill interpolator core
// Drives gaze samples through the valid/ready channels, predicts the filled
// stream for each beat and compares every emitted beat with it as a whole.
// ----------------------------------------------------------------------------
module testbench;
    import ggfi_pkg::*;

    localparam int MAX_FILL  = 63;
    localparam int HOLD_OFF  = 8 * 40 + 60;
    localparam longint LIMIT = 64'd30000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    ggfi_in_if  sample_in ();
    ggfi_out_if sample_out ();

    gaze_gap_fill_interpolator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample_in  (sample_in.sink),
        .sample_out (sample_out.source)
    );

    // Predictor state and configuration copy.
    logic [31:0] gap_limit;
    logic [31:0] period;
    bit          seen_sample;
    logic [31:0] kept_time;
    longint      kept_coord [8];

    ggfi_out_t filled_q [$];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  mismatches;
    int  beats_checked;
    int  samples_sent;
    int  gaps_filled;
    longint cycles;

    always #5 clk = ~clk;

    initial
    begin
        sample_in.valid  = 1'b0;
        sample_in.data   = '0;
        sample_out.ready = 1'b0;
    end

    // Floor division for a positive divisor.
    function automatic longint floor_div(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic longint coord_of(ggfi_in_t s, int j);
        case (j)
            0: return longint'(s.screen_x);
            1: return longint'(s.screen_y);
            2: return longint'(s.origin_x);
            3: return longint'(s.origin_y);
            4: return longint'(s.origin_z);
            5: return longint'(s.target_x);
            6: return longint'(s.target_y);
            default: return longint'(s.target_z);
        endcase
    endfunction

    function automatic ggfi_out_t make_beat(logic [31:0] ts, longint c [8],
                                            ggfi_in_t s, logic last);
        ggfi_out_t b;
        b.out_timestamp    = ts;
        b.out_screen_x     = c[0][23:0];
        b.out_screen_y     = c[1][23:0];
        b.out_origin_x     = c[2][23:0];
        b.out_origin_y     = c[3][23:0];
        b.out_origin_z     = c[4][23:0];
        b.out_target_x     = c[5][23:0];
        b.out_target_y     = c[6][23:0];
        b.out_target_z     = c[7][23:0];
        b.out_trial_number = s.trial_number;
        b.out_label_tag    = s.label_tag;
        b.is_last          = last;
        return b;
    endfunction

    // Work out the filled beats caused by one sample and update the kept one.
    task automatic predict_fill(ggfi_in_t s);
        longint now_c [8];
        longint mid_c [8];
        longint gap;
        longint den;
        longint num;
        longint inserts;
        logic [31:0] ts;
        inserts = 0;
        for (int j = 0; j < 8; j++)
            now_c[j] = coord_of(s, j);
        if (seen_sample && gap_limit != 0 && period != 0)
        begin
            gap = longint'(s.timestamp) - longint'(kept_time);
            if (gap > longint'(period) && gap <= longint'(gap_limit))
            begin
                inserts = (gap * 2 + longint'(period)) / (longint'(period) * 2) - 1;
                if (inserts > MAX_FILL)
                    inserts = MAX_FILL;
            end
        end
        if (inserts > 0)
            gaps_filled++;
        den = inserts + 1;
        for (longint k = 1; k <= inserts; k++)
        begin
            ts = kept_time + 32'(k * longint'(period));
            for (int j = 0; j < 8; j++)
            begin
                num = (now_c[j] - kept_coord[j]) * k;
                mid_c[j] = kept_coord[j] + floor_div(2 * num + den, 2 * den);
            end
            filled_q.push_back(make_beat(ts, mid_c, s, 1'b0));
        end
        filled_q.push_back(make_beat(s.timestamp, now_c, s, 1'b1));
        seen_sample = 1'b1;
        kept_time   = s.timestamp;
        for (int j = 0; j < 8; j++)
            kept_coord[j] = now_c[j];
    endtask

    // Send one sample beat, idling at random beforehand.
    task automatic send_sample(ggfi_in_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_in.valid <= 1'b0;
            @(posedge clk);
        end
        sample_in.valid <= 1'b1;
        sample_in.data  <= s;
        @(posedge clk iff sample_in.ready);
        predict_fill(s);
        samples_sent++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_GAP)
            gap_limit = value;
        else
            period = value;
    endtask

    // Let the block drain before a register change.
    task automatic drain();
        sample_in.valid <= 1'b0;
        while (filled_q.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    function automatic ggfi_in_t random_sample(logic [31:0] ts, int span);
        ggfi_in_t s;
        s = ggfi_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
        if (span > 0)
        begin
            s.screen_x = coord_t'($urandom_range(2 * span) - span);
            s.target_z = coord_t'($urandom_range(2 * span) - span);
        end
        s.timestamp = ts;
        return s;
    endfunction

    // Beat checker: compare against the oldest expectation.
    always @(posedge clk)
    begin
        ggfi_out_t want;
        if (rst_n)
        begin
            if (sample_out.valid && sample_out.ready)
            begin
                beats_checked++;
                if (filled_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat %h", sample_out.data);
                end
                else
                begin
                    want = filled_q.pop_front();
                    if (sample_out.data !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h",
                                     want, sample_out.data);
                    end
                end
            end
            sample_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Directed: pass-through, disabled filling, extremes of fields.
    task automatic test_pass_through();
        ggfi_in_t s;
        s = '0;
        send_sample(s);
        s = '1;
        send_sample(s);
        s.screen_x = coord_t'(24'h800000);
        s.target_z = coord_t'(24'h7FFFFF);
        s.timestamp = 32'd5000;
        send_sample(s);
    endtask

    // Directed: gaps, rounding, saturation, backwards time and wrap.
    task automatic test_gap_cases();
        ggfi_in_t s;
        drain();
        write_reg(CFG_MAX_GAP, 32'd100000);
        write_reg(CFG_PERIOD, 32'd1000);
        s = '0;
        s.timestamp = 32'd10000;
        send_sample(s);
        s.timestamp = 32'd12500;
        s.screen_x = coord_t'(24'h7FFFFF);
        s.target_z = coord_t'(24'h800000);
        send_sample(s);
        s.timestamp = 32'd14400;
        s.origin_y = coord_t'(-24'sd7);
        send_sample(s);
        s.timestamp = 32'd13000;
        send_sample(s);
        s.timestamp = 32'd14000;
        send_sample(s);
        s.timestamp = 32'd15001;
        send_sample(s);
        s.timestamp = 32'd95001;
        s.target_x = coord_t'(24'h7FFFFF);
        send_sample(s);
        s.timestamp = 32'd195002;
        send_sample(s);
        drain();
        write_reg(CFG_MAX_GAP, 32'hFFFFFFFF);
        write_reg(CFG_PERIOD, 32'h7FFFFFFF);
        s.timestamp = 32'h00000010;
        send_sample(s);
        s.timestamp = 32'hFFFFFFFF;
        s = random_sample(32'hFFFFFFFF, 0);
        send_sample(s);
        drain();
        write_reg(CFG_PERIOD, 32'd0);
        s = random_sample(32'd100, 0);
        send_sample(s);
        drain();
        write_reg(CFG_PERIOD, 32'hFFFFFFFF);
        s = random_sample(32'd500, 0);
        send_sample(s);
    endtask

    // Random stream: mostly gaps worth filling, a few disorderly samples.
    task automatic test_random_stream(int count, logic [31:0] per,
                                      logic [31:0] limit);
        logic [31:0] ts;
        int r;
        drain();
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_MAX_GAP, limit);
        ts = $urandom;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                ts = ts + per * $urandom_range(1, 5) + $urandom_range(per - 1);
            else if (r < 70)
                ts = ts + per * $urandom_range(6, 70);
            else if (r < 80)
                ts = ts - $urandom_range(3 * per);
            else
                ts = $urandom;
            send_sample(random_sample(ts, ($urandom_range(1)) ? 4096 : 0));
        end
    endtask

    initial
    begin
        gap_limit = 32'd0;
        period    = 32'd1000;
        seen_sample = 1'b0;
        kept_time = '0;
        foreach (kept_coord[j])
            kept_coord[j] = 0;
        mismatches = 0;
        beats_checked = 0;
        samples_sent = 0;
        gaps_filled = 0;
        cycles = 0;
        send_idle_pct = 23;
        recv_idle_pct = 66;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pass_through();
        test_gap_cases();
        test_random_stream(125, 32'd1000, 32'd60000);
        send_idle_pct = 66;
        recv_idle_pct = 23;
        test_random_stream(125, 32'd7, 32'd500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(110, 32'd250, 32'd3000);
        drain();
        $display("Sent %0d samples, checked %0d beats, %0d gaps filled.",
                 samples_sent, beats_checked, gaps_filled);
        if (mismatches == 0 && filled_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/ggfi_pkg.sv
rtl/core/ggfi_if.sv
rtl/core/ggfi_divider.sv
rtl/core/gaze_gap_fill_interpolator_core.sv
rtl/core/ggfi_checker.sv
bench/testbench.sv
